[rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the nearest point search block.
// Each macro samples on aclk and is quiet while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge
`define AST_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check that a consequent holds whenever the antecedent holds
`define AST_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

[rtl/nps_pkg.sv]
// Package for the nearest point search block: store sizes, field widths
// and request codes. Used by nps_ram users and by the top level.
`timescale 1ns / 1ps

package nps_pkg;

    localparam int POINT_DEPTH = 4096;
    localparam int COORD_BITS  = 24;
    localparam int IDX_W       = $clog2(POINT_DEPTH);
    localparam int CNT_W       = $clog2(POINT_DEPTH + 1);
    localparam int PT_W        = 3 * COORD_BITS;

    // Request kinds carried in s_tuser
    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_POS   = 2'd1,
        REQ_RAY   = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    // Configuration register indexes (byte address / 4)
    typedef enum logic [2:0] {
        REG_CAP    = 3'd0,
        REG_REL    = 3'd1,
        REG_ORG_X  = 3'd2,
        REG_ORG_Y  = 3'd3,
        REG_ORG_Z  = 3'd4,
        REG_NONE_5 = 3'd5,
        REG_NONE_6 = 3'd6,
        REG_NONE_7 = 3'd7
    } reg_idx_t;

endpackage

[rtl/nps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// Stands alone; no package needed.
`timescale 1ns / 1ps

module nps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/nearest_point_search.sv]
// Nearest point search: add and clear go straight to the done state and raise m_tvalid
// once the output register is free. Position and ray queries step through the stored points
// in order; a ray query skips the rest of the work for a point behind the ray origin. One shared
// 27x27 multiplier with a product register and a 106-bit accumulator does every multiply.
// One item at a time: s_tready returns in the cycle the result is registered.
// Reset (aresetn low, synchronous) empties the store and restores register defaults;
// store contents are left undefined and never read before written.
`timescale 1ns / 1ps

module nearest_point_search (
    input  logic          aclk,
    input  logic          aresetn,
    // x[23:0], y[47:24], z[71:48], dir_x[95:72], dir_y[119:96], dir_z[143:120],
    // max_distance[166:144], zero pad [167]
    input  logic [167:0]  s_tdata,
    // req_type[1:0]
    input  logic [1:0]    s_tuser,
    input  logic          s_tvalid,
    output logic          s_tready,
    // found[0], best_index[12:1], stored total[25:13], add_accepted[26], zero pad [31:27]
    output logic [31:0]   m_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    import nps_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_ACC, S_RD, S_OFS, S_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_MSQ, OP_L0, OP_L1, OP_L2, OP_B0, OP_B1, OP_B2, OP_B3,
        OP_E0, OP_E1, OP_E2, OP_D0, OP_D1, OP_D2,
        OP_X0, OP_X1, OP_Y0, OP_Y1, OP_Z0, OP_Z1,
        OP_SX0, OP_SX1, OP_SX2, OP_SY0, OP_SY1, OP_SY2, OP_SZ0, OP_SZ1, OP_SZ2
    } op_t;

    localparam int CB = COORD_BITS;
    localparam int OW = CB + 2;        // offset width
    localparam int CW = 2 * CB + 3;    // cross component magnitude width
    localparam int AW = 106;           // accumulator width

    // Configuration registers
    logic [CNT_W-1:0]     cap_reg;
    logic                 rel_reg;
    logic signed [CB-1:0] org_x_reg, org_y_reg, org_z_reg;

    // Request registers
    req_t                 req_reg;
    logic signed [CB-1:0] px_reg, py_reg, pz_reg, dx_reg, dy_reg, dz_reg;
    logic [22:0]          maxd_reg;

    // Control and result
    state_t               state_reg;
    op_t                  op_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic                 found_reg, added_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 out_valid_reg;
    logic [31:0]          out_data_reg;

    // Datapath
    logic signed [OW-1:0] ox_reg, oy_reg, oz_reg;
    logic [CW-1:0]        cx_reg, cy_reg, cz_reg;
    logic [45:0]          m2_reg;
    logic [49:0]          len2_reg;
    logic [103:0]         best_reg;
    logic signed [53:0]   prod_reg;
    logic signed [AW-1:0] acc_reg;

    logic [PT_W-1:0]      rd_data;
    logic                 accept, cfg_wr, can_add, last_pt;
    logic [CNT_W-1:0]     eff_cap;
    reg_idx_t             wr_idx;

    logic signed [26:0]   opa, opb;
    logic [5:0]           sh;
    logic                 op_clr, op_sub;
    logic signed [AW-1:0] term, acc_sum;
    logic                 closer;
    logic [CW-1:0]        c_abs;
    logic signed [OW-1:0] ox_next, oy_next, oz_next;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign wr_idx   = reg_idx_t'(paddr[4:2]);

    // Effective capacity: zero or oversize means the whole store
    assign eff_cap = (cap_reg == '0 || cap_reg > CNT_W'(POINT_DEPTH)) ?
                     CNT_W'(POINT_DEPTH) : cap_reg;
    assign can_add = (count_reg < eff_cap);
    assign last_pt = ({1'b0, idx_reg} + 1'b1) == count_reg;

    // Point store
    nps_ram #(.WIDTH(PT_W), .DEPTH(POINT_DEPTH)) u_store (
        .aclk  (aclk),
        .we    (accept && req_t'(s_tuser) == REQ_ADD && can_add),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (s_tdata[PT_W-1:0]),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    // Register read-back
    always_comb begin
        unique case (wr_idx)
            REG_CAP:   prdata = 32'(cap_reg);
            REG_REL:   prdata = 32'(rel_reg);
            REG_ORG_X: prdata = 32'(signed'(org_x_reg));
            REG_ORG_Y: prdata = 32'(signed'(org_y_reg));
            REG_ORG_Z: prdata = 32'(signed'(org_z_reg));
            default:   prdata = '0;
        endcase
    end

    // Offset of the stored point (plus origin in relative mode) from the query position
    always_comb begin
        logic signed [CB-1:0] rx, ry, rz;
        rx = rel_reg ? org_x_reg : '0;
        ry = rel_reg ? org_y_reg : '0;
        rz = rel_reg ? org_z_reg : '0;
        ox_next = OW'(signed'(rd_data[CB-1:0])) + OW'(rx) - OW'(px_reg);
        oy_next = OW'(signed'(rd_data[2*CB-1:CB])) + OW'(ry) - OW'(py_reg);
        oz_next = OW'(signed'(rd_data[3*CB-1:2*CB])) + OW'(rz) - OW'(pz_reg);
    end

    // Operand selection for the shared multiplier
    always_comb begin
        opa    = '0;
        opb    = '0;
        sh     = '0;
        op_clr = 1'b0;
        op_sub = 1'b0;
        unique case (op_reg)
            OP_MSQ: begin
                opa = {4'b0, maxd_reg}; opb = {4'b0, maxd_reg}; op_clr = 1'b1;
            end
            OP_L0: begin opa = 27'(dx_reg); opb = 27'(dx_reg); op_clr = 1'b1; end
            OP_L1: begin opa = 27'(dy_reg); opb = 27'(dy_reg); end
            OP_L2: begin opa = 27'(dz_reg); opb = 27'(dz_reg); end
            OP_B0: begin
                opa = {4'b0, m2_reg[22:0]}; opb = {2'b0, len2_reg[24:0]}; op_clr = 1'b1;
            end
            OP_B1: begin
                opa = {4'b0, m2_reg[22:0]}; opb = {2'b0, len2_reg[49:25]}; sh = 6'd25;
            end
            OP_B2: begin
                opa = {4'b0, m2_reg[45:23]}; opb = {2'b0, len2_reg[24:0]}; sh = 6'd23;
            end
            OP_B3: begin
                opa = {4'b0, m2_reg[45:23]}; opb = {2'b0, len2_reg[49:25]}; sh = 6'd48;
            end
            OP_E0: begin opa = 27'(ox_reg); opb = 27'(ox_reg); op_clr = 1'b1; end
            OP_E1: begin opa = 27'(oy_reg); opb = 27'(oy_reg); end
            OP_E2: begin opa = 27'(oz_reg); opb = 27'(oz_reg); end
            OP_D0: begin opa = 27'(ox_reg); opb = 27'(dx_reg); op_clr = 1'b1; end
            OP_D1: begin opa = 27'(oy_reg); opb = 27'(dy_reg); end
            OP_D2: begin opa = 27'(oz_reg); opb = 27'(dz_reg); end
            OP_X0: begin opa = 27'(oy_reg); opb = 27'(dz_reg); op_clr = 1'b1; end
            OP_X1: begin opa = 27'(oz_reg); opb = 27'(dy_reg); op_sub = 1'b1; end
            OP_Y0: begin opa = 27'(oz_reg); opb = 27'(dx_reg); op_clr = 1'b1; end
            OP_Y1: begin opa = 27'(ox_reg); opb = 27'(dz_reg); op_sub = 1'b1; end
            OP_Z0: begin opa = 27'(ox_reg); opb = 27'(dy_reg); op_clr = 1'b1; end
            OP_Z1: begin opa = 27'(oy_reg); opb = 27'(dx_reg); op_sub = 1'b1; end
            OP_SX0: begin
                opa = {1'b0, cx_reg[25:0]}; opb = {1'b0, cx_reg[25:0]}; op_clr = 1'b1;
            end
            OP_SX1: begin
                opa = {2'b0, cx_reg[50:26]}; opb = {1'b0, cx_reg[25:0]}; sh = 6'd27;
            end
            OP_SX2: begin
                opa = {2'b0, cx_reg[50:26]}; opb = {2'b0, cx_reg[50:26]}; sh = 6'd52;
            end
            OP_SY0: begin opa = {1'b0, cy_reg[25:0]}; opb = {1'b0, cy_reg[25:0]}; end
            OP_SY1: begin
                opa = {2'b0, cy_reg[50:26]}; opb = {1'b0, cy_reg[25:0]}; sh = 6'd27;
            end
            OP_SY2: begin
                opa = {2'b0, cy_reg[50:26]}; opb = {2'b0, cy_reg[50:26]}; sh = 6'd52;
            end
            OP_SZ0: begin opa = {1'b0, cz_reg[25:0]}; opb = {1'b0, cz_reg[25:0]}; end
            OP_SZ1: begin
                opa = {2'b0, cz_reg[50:26]}; opb = {1'b0, cz_reg[25:0]}; sh = 6'd27;
            end
            OP_SZ2: begin
                opa = {2'b0, cz_reg[50:26]}; opb = {2'b0, cz_reg[50:26]}; sh = 6'd52;
            end
            default: ;
        endcase
    end

    // Add or subtract the shifted product into the accumulator, or start it afresh
    assign term    = AW'(prod_reg) <<< sh;
    assign acc_sum = (op_clr ? AW'(0) : acc_reg) + (op_sub ? -term : term);
    assign closer  = acc_sum[103:0] < best_reg;
    assign c_abs   = acc_sum[CW-1] ? CW'(-acc_sum[CW-1:0]) : acc_sum[CW-1:0];

    // Sequencer, datapath and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_MSQ;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            cap_reg       <= CNT_W'(POINT_DEPTH);
            rel_reg       <= 1'b0;
            org_x_reg     <= '0;
            org_y_reg     <= '0;
            org_z_reg     <= '0;
        end else begin
            // Configuration writes
            if (cfg_wr && pready) begin
                unique case (wr_idx)
                    REG_CAP:   cap_reg   <= pwdata[CNT_W-1:0];
                    REG_REL:   rel_reg   <= pwdata[0];
                    REG_ORG_X: org_x_reg <= pwdata[CB-1:0];
                    REG_ORG_Y: org_y_reg <= pwdata[CB-1:0];
                    REG_ORG_Z: org_z_reg <= pwdata[CB-1:0];
                    default: ;
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (out_valid_reg && m_tready && state_reg != S_DONE) begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg      <= req_t'(s_tuser);
                        px_reg       <= s_tdata[CB-1:0];
                        py_reg       <= s_tdata[2*CB-1:CB];
                        pz_reg       <= s_tdata[3*CB-1:2*CB];
                        dx_reg       <= s_tdata[4*CB-1:3*CB];
                        dy_reg       <= s_tdata[5*CB-1:4*CB];
                        dz_reg       <= s_tdata[6*CB-1:5*CB];
                        maxd_reg     <= s_tdata[6*CB+22:6*CB];
                        found_reg    <= 1'b0;
                        best_idx_reg <= '0;
                        added_reg    <= (req_t'(s_tuser) == REQ_ADD) && can_add;
                        idx_reg      <= '0;
                        op_reg       <= OP_MSQ;
                        unique case (req_t'(s_tuser))
                            REQ_ADD: begin
                                if (can_add) begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                state_reg <= S_DONE;
                            end
                            REQ_CLEAR: begin
                                count_reg <= '0;
                                state_reg <= S_DONE;
                            end
                            REQ_POS, REQ_RAY: begin
                                if (count_reg != '0 && s_tdata[6*CB+22:6*CB] != '0) begin
                                    state_reg <= S_MUL;
                                end else begin
                                    state_reg <= S_DONE;
                                end
                            end
                        endcase
                    end
                end
                S_MUL: begin
                    prod_reg  <= opa * opb;
                    state_reg <= S_ACC;
                end
                S_ACC: begin
                    acc_reg <= acc_sum;
                    op_reg  <= op_t'(op_reg + 1'b1);
                    priority case (op_reg)
                        OP_MSQ: begin
                            m2_reg <= acc_sum[45:0];
                            if (req_reg == REQ_POS) begin
                                best_reg  <= 104'(acc_sum[45:0]);
                                state_reg <= S_RD;
                            end else begin
                                state_reg <= S_MUL;
                            end
                        end
                        OP_L2: begin
                            len2_reg  <= acc_sum[49:0];
                            state_reg <= (acc_sum[49:0] == '0) ? S_DONE : S_MUL;
                        end
                        OP_B3: begin
                            best_reg  <= acc_sum[103:0];
                            state_reg <= S_RD;
                        end
                        OP_E2, OP_SZ2: begin
                            if (closer) begin
                                best_reg     <= acc_sum[103:0];
                                best_idx_reg <= idx_reg;
                                found_reg    <= 1'b1;
                            end
                            state_reg <= last_pt ? S_DONE : S_RD;
                            idx_reg   <= idx_reg + 1'b1;
                        end
                        OP_D2: begin
                            // Skip points behind the ray origin
                            if (acc_sum[AW-1]) begin
                                state_reg <= last_pt ? S_DONE : S_RD;
                                idx_reg   <= idx_reg + 1'b1;
                            end else begin
                                state_reg <= S_MUL;
                            end
                        end
                        OP_X1: begin
                            cx_reg    <= c_abs;
                            state_reg <= S_MUL;
                        end
                        OP_Y1: begin
                            cy_reg    <= c_abs;
                            state_reg <= S_MUL;
                        end
                        OP_Z1: begin
                            cz_reg    <= c_abs;
                            state_reg <= S_MUL;
                        end
                        default: state_reg <= S_MUL;
                    endcase
                end
                S_RD: begin
                    state_reg <= S_OFS;
                end
                S_OFS: begin
                    ox_reg    <= ox_next;
                    oy_reg    <= oy_next;
                    oz_reg    <= oz_next;
                    op_reg    <= (req_reg == REQ_POS) ? OP_E0 : OP_D0;
                    state_reg <= S_MUL;
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (!out_valid_reg || m_tready) begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {5'b0, added_reg, count_reg,
                                          found_reg ? best_idx_reg : IDX_W'(0), found_reg};
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `AST_ALWAYS(a_count_bound, count_reg <= CNT_W'(POINT_DEPTH), "stored count above depth")
    `AST_IMPLY(a_found_index, m_tvalid && m_tdata[0], {1'b0, m_tdata[12:1]} < m_tdata[25:13], "bad index")
    `AST_IMPLY(a_add_count, m_tvalid && m_tdata[26], m_tdata[25:13] != '0, "accepted add with empty store")

endmodule
